FILE: rtl/core/sfri_pkg.sv
// ----------------------------------------------------------------------------
// sfri_pkg
// Shared types and constants for the spectral frame ring interpolator.
// ----------------------------------------------------------------------------
package sfri_pkg;

    localparam int Q_W    = 32;
    localparam int BIN_W  = 10;
    localparam int FIDX_W = 6;
    localparam int POS_W  = 40;
    localparam int CFG_W  = 10;
    localparam int FRM_CFG_W = 7;
    localparam int BIN_CFG_W = 10;

    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic REG_BINS_IN_USE   = 1'b1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [FRM_CFG_W-1:0] FRAMES_RST = 7'd64;
    localparam logic [BIN_CFG_W-1:0] BINS_RST   = 10'd513;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_BIN = 1'b1;

    // one stored bin: amplitude in the low half, frequency in the high half
    typedef struct packed {
        logic signed [Q_W-1:0] freq;
        logic signed [Q_W-1:0] amp;
    } t_word;

endpackage

FILE: rtl/core/sfri_ram.sv
// ----------------------------------------------------------------------------
// sfri_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sfri_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sfri_mod.sv
// ----------------------------------------------------------------------------
// sfri_mod
// Wraps the integer part of a frame position into [0, frames): radix-16
// restoring remainder on the magnitude, floor correction for negatives.
// ----------------------------------------------------------------------------
module sfri_mod #(
    parameter int FRAMES_MAX = 64,
    parameter int FRAC_BITS  = 16,
    localparam int FCW = $clog2(FRAMES_MAX + 1),
    localparam int FW  = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [sfri_pkg::POS_W-1:0] i_pos,
    input  logic [FCW-1:0]                    i_frames,
    output logic                              o_done,
    output logic [FW-1:0]                     o_lo,
    output logic [FW-1:0]                     o_hi,
    output logic [FRAC_BITS-1:0]              o_frac
);

    localparam int IP_W   = sfri_pkg::POS_W - FRAC_BITS;
    localparam int DIGITS = 4;
    localparam int STEPS  = (IP_W + DIGITS - 1) / DIGITS;
    localparam int DIG_W  = STEPS * DIGITS;
    localparam int CW     = $clog2(STEPS + 1);
    localparam int RW     = FCW + 1;

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [RW-1:0]        r_rem;
    logic [DIG_W-1:0]     r_shift;
    logic                 r_neg;
    logic [FRAC_BITS-1:0] r_frac;
    logic [FW-1:0]        r_lo;
    logic [FW-1:0]        r_hi;

    logic signed [IP_W-1:0] ip;
    logic [IP_W-1:0]        mag;
    logic [RW-1:0]          n_rem;
    logic [DIG_W-1:0]       n_shift;
    logic [RW-1:0]          frames_w;
    logic [RW-1:0]          lo_full;
    logic [RW-1:0]          lo_inc;
    logic [RW-1:0]          hi_full;

    assign ip       = i_pos[sfri_pkg::POS_W-1:FRAC_BITS];
    assign mag      = ip[IP_W-1] ? IP_W'(-ip) : IP_W'(ip);
    assign frames_w = RW'(i_frames);

    always_comb begin
        n_rem   = r_rem;
        n_shift = r_shift;
        for (int k = 0; k < DIGITS; k++) begin
            n_rem   = {n_rem[RW-2:0], n_shift[DIG_W-1]};
            n_shift = n_shift << 1;
            if (n_rem >= frames_w) begin
                n_rem = n_rem - frames_w;
            end
        end
    end

    assign lo_full = (r_neg && (r_rem != '0)) ? (frames_w - r_rem) : r_rem;
    assign lo_inc  = lo_full + RW'(1);
    assign hi_full = (lo_inc >= frames_w) ? '0 : lo_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_shift <= DIG_W'(mag);
            r_neg   <= ip[IP_W-1];
            r_frac  <= i_pos[FRAC_BITS-1:0];
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem   <= n_rem;
                r_shift <= n_shift;
            end else begin
                r_lo <= FW'(lo_full);
                r_hi <= FW'(hi_full);
            end
        end
    end

    assign o_done = r_done;
    assign o_lo   = r_lo;
    assign o_hi   = r_hi;
    assign o_frac = r_frac;

endmodule

FILE: rtl/core/sfri_lerp.sv
// ----------------------------------------------------------------------------
// sfri_lerp
// Linear interpolation of amplitude and frequency between two stored bins.
// Products are registered; rounding and the final add follow.
// ----------------------------------------------------------------------------
module sfri_lerp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  sfri_pkg::t_word                 i_lo,
    input  sfri_pkg::t_word                 i_hi,
    input  logic [FRAC_BITS-1:0]            i_frac,
    output logic signed [sfri_pkg::Q_W-1:0] o_amp,
    output logic signed [sfri_pkg::Q_W-1:0] o_freq
);

    localparam int QW = sfri_pkg::Q_W;
    localparam int DW = QW + 1;
    localparam int PW = DW + FRAC_BITS + 1;
    localparam logic [PW-1:0] ROUND =
        {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    logic signed [DW-1:0]        d_amp;
    logic signed [DW-1:0]        d_freq;
    logic signed [FRAC_BITS:0]   f_s;
    logic signed [PW-1:0]        r_p_amp;
    logic signed [PW-1:0]        r_p_freq;
    logic signed [QW-1:0]        r_a_amp;
    logic signed [QW-1:0]        r_a_freq;
    logic signed [PW-1:0]        s_amp;
    logic signed [PW-1:0]        s_freq;

    assign d_amp  = DW'(i_hi.amp) - DW'(i_lo.amp);
    assign d_freq = DW'(i_hi.freq) - DW'(i_lo.freq);
    assign f_s    = $signed({1'b0, i_frac});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p_amp  <= PW'(d_amp) * PW'(f_s);
            r_p_freq <= PW'(d_freq) * PW'(f_s);
            r_a_amp  <= i_lo.amp;
            r_a_freq <= i_lo.freq;
        end
    end

    // floor shift after the half-LSB round
    assign s_amp  = (r_p_amp + $signed(ROUND)) >>> FRAC_BITS;
    assign s_freq = (r_p_freq + $signed(ROUND)) >>> FRAC_BITS;

    assign o_amp  = r_a_amp + QW'(s_amp);
    assign o_freq = r_a_freq + QW'(s_freq);

endmodule

FILE: rtl/core/spectral_frame_ring_interp.sv
// ----------------------------------------------------------------------------
// spectral_frame_ring_interp
// Ring of spectral frames with linear interpolation between adjacent frames.
//
// Input channel (i_valid / o_ready): i_kind selects a bin write into the
// current frame or an interpolated bin read at a fractional frame position.
// Output channel (o_valid / i_ready): one result transaction per input
// transaction, in order. Config port: i_cfg_we, i_cfg_index, i_cfg_data;
// index 0 frames_in_use (also rewinds the write frame), index 1 bins_in_use.
// A write's result is registered and is valid in the cycle after acceptance;
// the block can take a new transaction in the next cycle if i_ready is high.
// A read: the frame wrap runs 4 remainder bits per cycle, then the two frames
// are read one after the other through the single frame-store port, then the
// multiply; no new transaction is taken before the read's result is loaded.
// Reset: the frame store is cleared one word a cycle, with o_ready low; config
// writes are still taken. A stalled receiver holds the result in the output
// register; o_ready stays low until it is taken or is being taken.
// ----------------------------------------------------------------------------
module spectral_frame_ring_interp #(
    parameter int FRAMES_MAX = 64,
    parameter int BINS_MAX   = 513,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_kind,
    input  logic [sfri_pkg::BIN_W-1:0]            i_bin,
    input  logic signed [sfri_pkg::Q_W-1:0]       i_amplitude,
    input  logic signed [sfri_pkg::Q_W-1:0]       i_frequency,
    input  logic                                  i_frame_last,
    input  logic signed [sfri_pkg::POS_W-1:0]     i_read_position,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [sfri_pkg::Q_W-1:0]       o_out_amplitude,
    output logic signed [sfri_pkg::Q_W-1:0]       o_out_frequency,
    output logic [sfri_pkg::FIDX_W-1:0]           o_frame_index,
    output logic                                  o_status,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [sfri_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int DEPTH  = FRAMES_MAX * BINS_MAX;
    localparam int AW     = $clog2(DEPTH);
    localparam int FW     = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
    localparam int FCW    = $clog2(FRAMES_MAX + 1);
    localparam int FCMP_W = (FCW > sfri_pkg::FRM_CFG_W) ? FCW : sfri_pkg::FRM_CFG_W;
    localparam int BCW    = $clog2(BINS_MAX + 1);
    localparam int BCMP_W = (BCW > sfri_pkg::BIN_CFG_W) ? BCW : sfri_pkg::BIN_CFG_W;
    localparam int QW     = sfri_pkg::Q_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_RDLO  = 3'd3;
    localparam logic [2:0] ST_RDHI  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    function automatic logic [AW-1:0] addr_of(input logic [FW-1:0] frame,
                                              input logic [sfri_pkg::BIN_W-1:0] bin);
        logic [AW-1:0] base;
        base = AW'(frame) * AW'(BINS_MAX);
        return base + AW'(bin);
    endfunction

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [AW-1:0]                r_clr_addr;
    logic [sfri_pkg::FRM_CFG_W-1:0] r_frames_in_use;
    logic [sfri_pkg::BIN_CFG_W-1:0] r_bins_in_use;
    logic [FW-1:0]                r_write_frame;
    logic [sfri_pkg::BIN_W-1:0]   r_bin;
    logic                         r_bad;
    sfri_pkg::t_word              r_lo_word;

    logic                         r_o_valid;
    logic signed [QW-1:0]         r_o_amp;
    logic signed [QW-1:0]         r_o_freq;
    logic [sfri_pkg::FIDX_W-1:0]  r_o_fidx;
    logic                         r_o_status;

    logic [FCMP_W-1:0]            frames_eff;
    logic [BCMP_W-1:0]            bins_eff;
    logic                         bad_in;
    logic                         out_free;
    logic                         in_acc;
    logic                         wr_acc;
    logic                         rd_acc;
    logic [FW-1:0]                wf;
    logic [FCMP_W-1:0]            wf_inc;
    logic [FW-1:0]                wf_next;

    logic                         mem_we;
    logic [AW-1:0]                mem_addr;
    sfri_pkg::t_word              mem_wdata;
    sfri_pkg::t_word              mem_rdata;

    logic                         mod_done;
    logic [FW-1:0]                mod_lo;
    logic [FW-1:0]                mod_hi;
    logic [FRAC_BITS-1:0]         mod_frac;
    logic signed [QW-1:0]         lerp_amp;
    logic signed [QW-1:0]         lerp_freq;
    logic                         out_load;

    // effective ring size and bin count
    always_comb begin
        if (r_frames_in_use == '0) begin
            frames_eff = FCMP_W'(1);
        end else if (FCMP_W'(r_frames_in_use) > FCMP_W'(FRAMES_MAX)) begin
            frames_eff = FCMP_W'(FRAMES_MAX);
        end else begin
            frames_eff = FCMP_W'(r_frames_in_use);
        end
        if (BCMP_W'(r_bins_in_use) > BCMP_W'(BINS_MAX)) begin
            bins_eff = BCMP_W'(BINS_MAX);
        end else begin
            bins_eff = BCMP_W'(r_bins_in_use);
        end
    end

    assign bad_in   = BCMP_W'(i_bin) >= bins_eff;
    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_free;
    assign in_acc   = i_valid && o_ready;
    assign wr_acc   = in_acc && (i_kind == sfri_pkg::KIND_WRITE);
    assign rd_acc   = in_acc && (i_kind == sfri_pkg::KIND_READ);

    assign wf      = (FCMP_W'(r_write_frame) < frames_eff) ? r_write_frame : '0;
    assign wf_inc  = FCMP_W'(wf) + FCMP_W'(1);
    assign wf_next = (wf_inc >= frames_eff) ? '0 : FW'(wf_inc);

    // frame store port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = addr_of(wf, i_bin);
        mem_wdata = '{freq: i_frequency, amp: i_amplitude};
        priority if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == ST_RDLO) begin
            mem_addr = addr_of(mod_lo, r_bin);
        end else if (r_state == ST_RDHI) begin
            mem_addr = addr_of(mod_hi, r_bin);
        end else begin
            mem_we = wr_acc && !bad_in;
        end
    end

    sfri_ram #(
        .WIDTH ($bits(sfri_pkg::t_word)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    sfri_mod #(
        .FRAMES_MAX (FRAMES_MAX),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rd_acc),
        .i_pos    (i_read_position),
        .i_frames (FCW'(frames_eff)),
        .o_done   (mod_done),
        .o_lo     (mod_lo),
        .o_hi     (mod_hi),
        .o_frac   (mod_frac)
    );

    sfri_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .i_clk  (i_clk),
        .i_load (r_state == ST_WAIT),
        .i_lo   (r_lo_word),
        .i_hi   (mem_rdata),
        .i_frac (mod_frac),
        .o_amp  (lerp_amp),
        .o_freq (lerp_freq)
    );

    assign out_load = (r_state == ST_OUT) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (rd_acc) n_state = ST_MOD;
            ST_MOD:   if (mod_done) n_state = ST_RDLO;
            ST_RDLO:  n_state = ST_RDHI;
            ST_RDHI:  n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr_addr      <= '0;
            r_frames_in_use <= sfri_pkg::FRAMES_RST;
            r_bins_in_use   <= sfri_pkg::BINS_RST;
            r_write_frame   <= '0;
            r_o_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (wr_acc) begin
                r_write_frame <= i_frame_last ? wf_next : wf;
            end
            if (wr_acc || out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sfri_pkg::REG_FRAMES_IN_USE: begin
                        r_frames_in_use <= i_cfg_data[sfri_pkg::FRM_CFG_W-1:0];
                        r_write_frame   <= '0;
                    end
                    sfri_pkg::REG_BINS_IN_USE: begin
                        r_bins_in_use <= i_cfg_data[sfri_pkg::BIN_CFG_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_bin <= i_bin;
            r_bad <= bad_in;
        end
        if (r_state == ST_RDHI) begin
            r_lo_word <= mem_rdata;
        end
        if (wr_acc) begin
            r_o_amp    <= '0;
            r_o_freq   <= '0;
            r_o_fidx   <= sfri_pkg::FIDX_W'(wf);
            r_o_status <= bad_in ? sfri_pkg::STATUS_BAD_BIN : sfri_pkg::STATUS_OK;
        end else if (out_load) begin
            r_o_amp    <= r_bad ? '0 : lerp_amp;
            r_o_freq   <= r_bad ? '0 : lerp_freq;
            r_o_fidx   <= sfri_pkg::FIDX_W'(mod_lo);
            r_o_status <= r_bad ? sfri_pkg::STATUS_BAD_BIN : sfri_pkg::STATUS_OK;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_out_amplitude = r_o_amp;
    assign o_out_frequency = r_o_freq;
    assign o_frame_index   = r_o_fidx;
    assign o_status        = r_o_status;

    a_no_accept_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> out_free)
        else $error("transaction accepted while result register is held");

    a_write_frame_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> (FCMP_W'(r_write_frame) < frames_eff))
        else $error("write frame outside the ring");

    a_store_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == ST_CLEAR) || (r_state == ST_IDLE)))
        else $error("frame store written during a read");

    a_mod_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> ((FCMP_W'(mod_lo) < frames_eff) && (FCMP_W'(mod_hi) < frames_eff)))
        else $error("wrapped frame out of range");

    a_read_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDLO) |=> (r_state == ST_RDHI) ##1 (r_state == ST_WAIT))
        else $error("read sequence broken");

endmodule

FILE: tb/sfri_ring_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfri_ring_checker
// Watches the transaction, result and register ports of the frame ring,
// keeps its own copy of the ring and registers, predicts each result and
// compares results in order. Hands the failure and outstanding counts up.
// ----------------------------------------------------------------------------
module sfri_ring_checker #(
    parameter int FRAMES_MAX = 64,
    parameter int BINS_MAX   = 513,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_ready,
    input  logic                              i_kind,
    input  logic [sfri_pkg::BIN_W-1:0]        i_bin,
    input  logic signed [sfri_pkg::Q_W-1:0]   i_amplitude,
    input  logic signed [sfri_pkg::Q_W-1:0]   i_frequency,
    input  logic                              i_frame_last,
    input  logic signed [sfri_pkg::POS_W-1:0] i_read_position,
    input  logic                              o_valid,
    input  logic                              i_ready,
    input  logic signed [sfri_pkg::Q_W-1:0]   o_out_amplitude,
    input  logic signed [sfri_pkg::Q_W-1:0]   o_out_frequency,
    input  logic [sfri_pkg::FIDX_W-1:0]       o_frame_index,
    input  logic                              o_status,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [sfri_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_mismatches,
    output int                                o_outstanding
);

    typedef struct packed {
        logic signed [sfri_pkg::Q_W-1:0] amp;
        logic signed [sfri_pkg::Q_W-1:0] freq;
        logic [sfri_pkg::FIDX_W-1:0]     fidx;
        logic                            status;
    } t_interp_result;

    sfri_pkg::t_word ring_store [FRAMES_MAX*BINS_MAX];
    int unsigned     write_frame;
    int unsigned     frames_reg;
    int unsigned     bins_reg;
    t_interp_result  expected_bins [$];
    int              mismatch_cnt = 0;

    // a + floor((f*(b-a) + half) / 2^FRAC_BITS)
    function automatic logic signed [sfri_pkg::Q_W-1:0] blend(
        input logic signed [sfri_pkg::Q_W-1:0] a,
        input logic signed [sfri_pkg::Q_W-1:0] b,
        input longint f);
        longint p;
        p = f * (longint'(b) - longint'(a)) + (longint'(1) <<< (FRAC_BITS - 1));
        return sfri_pkg::Q_W'(longint'(a) + (p >>> FRAC_BITS));
    endfunction

    function automatic t_interp_result predict_bin(
        input logic kind,
        input logic [sfri_pkg::BIN_W-1:0] bin,
        input logic signed [sfri_pkg::Q_W-1:0] amp,
        input logic signed [sfri_pkg::Q_W-1:0] freq,
        input logic last,
        input logic signed [sfri_pkg::POS_W-1:0] pos);
        t_interp_result  r;
        int unsigned     frames, bin_cnt, wf, nx, lo, hi;
        longint          posx, period, rem, frac;
        sfri_pkg::t_word w_lo, w_hi;
        frames  = (frames_reg == 0) ? 1 : (frames_reg > FRAMES_MAX) ? FRAMES_MAX : frames_reg;
        bin_cnt = (bins_reg > BINS_MAX) ? BINS_MAX : bins_reg;
        r = '0;
        r.status = (bin >= bin_cnt) ? sfri_pkg::STATUS_BAD_BIN : sfri_pkg::STATUS_OK;
        if (kind == sfri_pkg::KIND_WRITE) begin
            wf = (write_frame < frames) ? write_frame : 0;
            r.fidx = sfri_pkg::FIDX_W'(wf);
            if (r.status == sfri_pkg::STATUS_OK) begin
                ring_store[wf * BINS_MAX + bin] = '{freq: freq, amp: amp};
            end
            if (last) begin
                nx = wf + 1;
                write_frame = (nx >= frames) ? 0 : nx;
            end else begin
                write_frame = wf;
            end
        end else begin
            posx   = longint'(pos);
            period = longint'(frames) << FRAC_BITS;
            rem    = posx % period;
            if (rem < 0) begin
                rem += period;
            end
            lo   = int'(rem >>> FRAC_BITS);
            frac = rem & ((longint'(1) << FRAC_BITS) - 1);
            if (lo >= frames) begin
                lo = 0;
            end
            hi = (lo + 1 >= frames) ? 0 : lo + 1;
            r.fidx = sfri_pkg::FIDX_W'(lo);
            if (r.status == sfri_pkg::STATUS_OK) begin
                w_lo  = ring_store[lo * BINS_MAX + bin];
                w_hi  = ring_store[hi * BINS_MAX + bin];
                r.amp  = blend(w_lo.amp, w_hi.amp, frac);
                r.freq = blend(w_lo.freq, w_hi.freq, frac);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_interp_result got;
        t_interp_result want;
        if (!i_rst_n) begin
            foreach (ring_store[k]) ring_store[k] = '0;
            write_frame = 0;
            frames_reg  = sfri_pkg::FRAMES_RST;
            bins_reg    = sfri_pkg::BINS_RST;
            expected_bins.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sfri_pkg::REG_FRAMES_IN_USE) begin
                    frames_reg  = i_cfg_data[sfri_pkg::FRM_CFG_W-1:0];
                    write_frame = 0;
                end else begin
                    bins_reg = i_cfg_data[sfri_pkg::BIN_CFG_W-1:0];
                end
            end
            if (o_valid && i_ready) begin
                got = '{o_out_amplitude, o_out_frequency, o_frame_index, o_status};
                if (expected_bins.size() == 0) begin
                    if (mismatch_cnt < 10) begin
                        $display("%0t: unexpected result amp %h freq %h frame %0d status %0d",
                                 $time, got.amp, got.freq, got.fidx, got.status);
                    end
                    mismatch_cnt++;
                end else begin
                    want = expected_bins.pop_front();
                    if (got.amp !== want.amp || got.freq !== want.freq ||
                        got.fidx !== want.fidx || got.status !== want.status) begin
                        if (mismatch_cnt < 10) begin
                            $display("%0t: mismatch exp amp %h freq %h frame %0d status %0d",
                                     $time, want.amp, want.freq, want.fidx, want.status);
                            $display("%0t:          got amp %h freq %h frame %0d status %0d",
                                     $time, got.amp, got.freq, got.fidx, got.status);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                expected_bins.push_back(predict_bin(i_kind, i_bin, i_amplitude, i_frequency,
                                                    i_frame_last, i_read_position));
            end
        end
        o_outstanding = expected_bins.size();
        o_mismatches  = mismatch_cnt;
    end

endmodule

FILE: tb/spectral_frame_ring_interp_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectral_frame_ring_interp_tb
// Drives bin writes and interpolated reads into the frame ring under several
// ring sizes, with random gaps and stalls on both channels and one long
// output stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module spectral_frame_ring_interp_tb;

    localparam int FRAMES_MAX    = 64;
    localparam int BINS_MAX      = 513;
    localparam int FRAC_BITS     = 16;
    localparam int FRAME_ONE     = 1 << FRAC_BITS;
    localparam int HOT_BINS      = 12;
    localparam int PRESSURE_HOLD = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_valid         = 1'b0;
    logic                              o_ready;
    logic                              i_kind          = sfri_pkg::KIND_WRITE;
    logic [sfri_pkg::BIN_W-1:0]        i_bin           = '0;
    logic signed [sfri_pkg::Q_W-1:0]   i_amplitude     = '0;
    logic signed [sfri_pkg::Q_W-1:0]   i_frequency     = '0;
    logic                              i_frame_last    = 1'b0;
    logic signed [sfri_pkg::POS_W-1:0] i_read_position = '0;
    logic                              o_valid;
    logic                              i_ready         = 1'b0;
    logic signed [sfri_pkg::Q_W-1:0]   o_out_amplitude;
    logic signed [sfri_pkg::Q_W-1:0]   o_out_frequency;
    logic [sfri_pkg::FIDX_W-1:0]       o_frame_index;
    logic                              o_status;
    logic                              i_cfg_we        = 1'b0;
    logic                              i_cfg_index     = sfri_pkg::REG_FRAMES_IN_USE;
    logic [sfri_pkg::CFG_W-1:0]        i_cfg_data      = '0;

    int   mismatches;
    int   outstanding;
    int   frames_eff  = FRAMES_MAX;
    int   bins_eff    = BINS_MAX;
    bit   tx_calm     = 1'b0;
    bit   rx_calm     = 1'b0;
    bit   pressure_go = 1'b0;
    logic rx_hold     = 1'b0;
    logic rx_took     = 1'b0;
    int   rx_wait     = 0;
    int   cycle_cnt   = 0;

    always #5 i_clk = ~i_clk;

    spectral_frame_ring_interp #(
        .FRAMES_MAX (FRAMES_MAX),
        .BINS_MAX   (BINS_MAX),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_bin           (i_bin),
        .i_amplitude     (i_amplitude),
        .i_frequency     (i_frequency),
        .i_frame_last    (i_frame_last),
        .i_read_position (i_read_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_amplitude (o_out_amplitude),
        .o_out_frequency (o_out_frequency),
        .o_frame_index   (o_frame_index),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    sfri_ring_checker #(
        .FRAMES_MAX (FRAMES_MAX),
        .BINS_MAX   (BINS_MAX),
        .FRAC_BITS  (FRAC_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_bin           (i_bin),
        .i_amplitude     (i_amplitude),
        .i_frequency     (i_frequency),
        .i_frame_last    (i_frame_last),
        .i_read_position (i_read_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_amplitude (o_out_amplitude),
        .o_out_frequency (o_out_frequency),
        .o_frame_index   (o_frame_index),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // result side: random wait after each transaction, plus the long hold
    always @(posedge i_clk) begin
        rx_took <= o_valid && i_ready;
    end

    always @(negedge i_clk) begin : rx_pace
        int w;
        if (rx_took) begin
            w = rx_calm ? 0 : $urandom_range(0, 14);
        end else begin
            w = (rx_wait > 0) ? rx_wait - 1 : 0;
        end
        rx_wait <= w;
        i_ready <= !rx_hold && w == 0;
    end

    initial begin : rx_pressure
        wait (pressure_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (PRESSURE_HOLD) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [sfri_pkg::Q_W-1:0] sample_q16();
        if ($urandom_range(0, 7) != 0) begin
            return $urandom;
        end
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_txn(input logic kind, input logic [sfri_pkg::BIN_W-1:0] bin,
                            input logic [sfri_pkg::Q_W-1:0] amp,
                            input logic [sfri_pkg::Q_W-1:0] freq,
                            input logic last, input logic [sfri_pkg::POS_W-1:0] pos);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_bin           <= bin;
        i_amplitude     <= amp;
        i_frequency     <= freq;
        i_frame_last    <= last;
        i_read_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_write(input logic [sfri_pkg::BIN_W-1:0] bin,
                              input logic [sfri_pkg::Q_W-1:0] amp,
                              input logic [sfri_pkg::Q_W-1:0] freq, input logic last);
        send_txn(sfri_pkg::KIND_WRITE, bin, amp, freq, last,
                 sfri_pkg::POS_W'({$urandom, $urandom}));
    endtask

    task automatic send_read(input logic [sfri_pkg::BIN_W-1:0] bin,
                             input logic [sfri_pkg::POS_W-1:0] pos);
        send_txn(sfri_pkg::KIND_READ, bin, $urandom, $urandom, 1'($urandom), pos);
    endtask

    task automatic random_phase(input int count);
        int unsigned                hot, pick, base, frm;
        int                         k;
        longint                     pos;
        logic [sfri_pkg::BIN_W-1:0] bin;
        for (int n = 0; n < count; n++) begin
            hot  = (bins_eff == 0) ? 1 : (bins_eff < HOT_BINS) ? bins_eff : HOT_BINS;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                bin = sfri_pkg::BIN_W'($urandom_range(0, hot - 1));
            end else if (pick < 90) begin
                bin = sfri_pkg::BIN_W'($urandom_range(0, (bins_eff == 0) ? 0 : bins_eff - 1));
            end else begin
                bin = sfri_pkg::BIN_W'($urandom_range(0, 1023));
            end
            if ($urandom_range(0, 99) < 55) begin
                send_write(bin, sample_q16(), sample_q16(), $urandom_range(0, 4) == 0);
            end else begin
                frm  = $urandom_range(0, frames_eff - 1);
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    base = $urandom_range(0, frames_eff * FRAME_ONE - 1);
                    k    = int'($urandom_range(0, 6)) - 3;
                    pos  = longint'(base) + longint'(k) * frames_eff * FRAME_ONE;
                end else if (pick < 85) begin
                    pos = longint'(frm) * FRAME_ONE + ($urandom_range(0, 1) ? FRAME_ONE - 1 : 0);
                end else begin
                    pos = longint'({$urandom, $urandom});
                end
                send_read(bin, sfri_pkg::POS_W'(pos));
            end
        end
    endtask

    // drains the block, rewrites both registers, then runs random traffic
    task automatic run_phase(input logic [sfri_pkg::CFG_W-1:0] frames_raw,
                             input logic [sfri_pkg::CFG_W-1:0] bins_raw,
                             input int count, input bit calm_tx, input bit calm_rx,
                             input bit squeeze);
        int unsigned frm;
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sfri_pkg::REG_FRAMES_IN_USE;
        i_cfg_data  <= frames_raw;
        @(negedge i_clk);
        i_cfg_index <= sfri_pkg::REG_BINS_IN_USE;
        i_cfg_data  <= bins_raw;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        frm        = frames_raw[sfri_pkg::FRM_CFG_W-1:0];
        frames_eff = (frm == 0) ? 1 : (frm > FRAMES_MAX) ? FRAMES_MAX : frm;
        bins_eff   = (bins_raw > BINS_MAX) ? BINS_MAX : bins_raw;
        tx_calm    = calm_tx;
        rx_calm    = calm_rx;
        if (squeeze) begin
            pressure_go = 1'b1;
        end
        random_phase(count);
    endtask

    initial begin : stimulus
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes at the edges of the default ring
        send_write(10'd0,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_write(10'd512,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_write(10'd0,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_write(10'd512,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_write(10'd513,  32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
        send_write(10'd1023, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_read(10'd0,    40'h00_0000_0000);
        send_read(10'd0,    40'h00_0000_8000);
        send_read(10'd0,    40'h00_0000_FFFF);
        send_read(10'd512,  40'h00_0001_8000);
        send_read(10'd0,    40'h00_003F_8000);
        send_read(10'd0,    40'hFF_FFFF_FFFF);
        send_read(10'd0,    40'h80_0000_0000);
        send_read(10'd512,  40'h7F_FFFF_FFFF);
        send_read(10'd513,  40'h00_0002_4000);
        send_read(10'd1023, 40'hFF_FFFF_8000);
        send_read(10'd512,  40'hFF_FF3F_C000);

        run_phase(10'd4,    10'd8,    260, 1'b0, 1'b0, 1'b0);
        run_phase(10'd1,    10'd2,    200, 1'b1, 1'b1, 1'b0);
        run_phase(10'd0,    10'd513,  150, 1'b0, 1'b0, 1'b0);
        run_phase(10'd1023, 10'd1023, 200, 1'b0, 1'b1, 1'b0);
        run_phase(10'd64,   10'd1,    120, 1'b1, 1'b0, 1'b0);
        run_phase(10'd7,    10'd0,     80, 1'b0, 1'b0, 1'b0);
        run_phase(10'd16,   10'd40,   250, 1'b1, 1'b0, 1'b1);
        run_phase(10'd3,    10'd17,   250, 1'($urandom), 1'($urandom), 1'b0);
        run_phase(10'd64,   10'd513,  300, 1'b0, 1'b0, 1'b0);

        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
